/* hw/rtl/sxbg_pkg.sv */
// Package for the seeded xoshiro256** byte generator.
// Holds the splitmix64 constants, field widths and the sequencer state type.
// No dependencies.
package sxbg_pkg;

    localparam int WORD_W  = 64;
    localparam int HALF_W  = 32;
    localparam int COUNT_W = 10;
    localparam int VB_W    = 4;

    localparam logic [WORD_W-1:0] GOLDEN_GAMMA = 64'h9E3779B97F4A7C15;
    localparam logic [WORD_W-1:0] MIX_MUL_A    = 64'hBF58476D1CE4E5B9;
    localparam logic [WORD_W-1:0] MIX_MUL_B    = 64'h94D049BB133111EB;

    localparam logic ACT_RESEED   = 1'b0;
    localparam logic ACT_GENERATE = 1'b1;

    typedef enum logic [9:0] {
        S_IDLE     = 10'b00_0000_0001,
        S_MIX_ADD  = 10'b00_0000_0010,
        S_MUL_A    = 10'b00_0000_0100,
        S_XOR27    = 10'b00_0000_1000,
        S_MUL_B    = 10'b00_0001_0000,
        S_XOR31    = 10'b00_0010_0000,
        S_ZCHK     = 10'b00_0100_0000,
        S_GEN_MUL5 = 10'b00_1000_0000,
        S_GEN_MUL9 = 10'b01_0000_0000,
        S_GEN_OUT  = 10'b10_0000_0000
    } state_t;

endpackage

/* hw/rtl/seeded_xoshiro_byte_generator.sv */
// Top level of the seeded xoshiro256** byte generator.
// Depends on sxbg_pkg.
//
// Deterministic random byte source. An action 0 beat reseeds: the seed register is expanded
// into the four 64-bit lanes by four splitmix64 steps, each running its two 64x64 multiplies
// on one shared 32x32 multiplier. The same expansion of seed 0 runs right after reset, while
// in_stall is high. An action 1 beat asks for byte_count bytes (capped at MAX_WORDS*8) and
// returns ceil(count/8) words, each through two shift-add states and one output load, which
// waits while a stalled word holds the output register; a zero count returns nothing. in_stall
// stays high until the last word is loaded into the output register. The seed port takes
// writes at any time.
module seeded_xoshiro_byte_generator #(
    parameter int MAX_WORDS = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [sxbg_pkg::WORD_W-1:0] seed,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        action,
    input  logic [sxbg_pkg::COUNT_W-1:0] byte_count,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [sxbg_pkg::WORD_W-1:0] random_word,
    output logic [sxbg_pkg::VB_W-1:0]   valid_bytes,
    output logic                        last_word
);
    import sxbg_pkg::*;

    localparam logic [COUNT_W-1:0] MAX_BYTES = COUNT_W'(MAX_WORDS * 8);

    state_t              state_reg, state_next;
    logic [WORD_W-1:0]   seed_reg;
    logic [WORD_W-1:0]   acc_reg, acc_next;
    logic [WORD_W-1:0]   z_reg, z_next;
    logic [WORD_W-1:0]   prod_reg, prod_next;
    logic [1:0]          mph_reg, mph_next;
    logic [1:0]          idx_reg, idx_next;
    logic [WORD_W-1:0]   lane_reg [4];
    logic [WORD_W-1:0]   lane_next [4];
    logic [COUNT_W-1:0]  rem_reg, rem_next;
    logic [WORD_W-1:0]   word_reg, word_next;
    logic [VB_W-1:0]     vb_reg, vb_next;
    logic                last_reg, last_next;
    logic                out_valid_reg, out_valid_next;
    logic [WORD_W-1:0]   out_word_reg, out_word_next;
    logic [VB_W-1:0]     out_vb_reg, out_vb_next;
    logic                out_last_reg, out_last_next;

    logic                in_take;
    logic                out_free;
    logic [WORD_W-1:0]   acc_sum;
    logic [WORD_W-1:0]   mul_const;
    logic [HALF_W-1:0]   mul_a, mul_b;
    logic [WORD_W-1:0]   mul_p;
    logic [WORD_W-1:0]   rot7;
    logic [WORD_W-1:0]   s2x, s3x;

    assign cfg_ready   = 1'b1;
    assign in_stall    = (state_reg != S_IDLE);
    assign in_take     = in_valid && !in_stall;
    assign out_free    = !out_valid_reg || !out_stall;
    assign out_valid   = out_valid_reg;
    assign random_word = out_word_reg;
    assign valid_bytes = out_vb_reg;
    assign last_word   = out_last_reg;

    assign acc_sum   = acc_reg + GOLDEN_GAMMA;
    assign mul_const = (state_reg == S_MUL_A) ? MIX_MUL_A : MIX_MUL_B;
    assign rot7      = {z_reg[56:0], z_reg[63:57]};
    assign s2x       = lane_reg[2] ^ lane_reg[0];
    assign s3x       = lane_reg[3] ^ lane_reg[1];

    // shared 32x32 multiplier: lo*lo, then the two cross terms into the high half
    always_comb
    begin
        case (mph_reg)
            2'd0:
            begin
                mul_a = z_reg[HALF_W-1:0];
                mul_b = mul_const[HALF_W-1:0];
            end
            2'd1:
            begin
                mul_a = z_reg[HALF_W-1:0];
                mul_b = mul_const[WORD_W-1:HALF_W];
            end
            default:
            begin
                mul_a = z_reg[WORD_W-1:HALF_W];
                mul_b = mul_const[HALF_W-1:0];
            end
        endcase
        mul_p = WORD_W'(mul_a) * WORD_W'(mul_b);
    end

    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        z_next         = z_reg;
        prod_next      = prod_reg;
        mph_next       = mph_reg;
        idx_next       = idx_reg;
        lane_next      = lane_reg;
        rem_next       = rem_reg;
        word_next      = word_reg;
        vb_next        = vb_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_word_next  = out_word_reg;
        out_vb_next    = out_vb_reg;
        out_last_next  = out_last_reg;

        unique case (state_reg) inside
            S_IDLE:
            begin
                if (in_take)
                begin
                    if (action == ACT_RESEED)
                    begin
                        acc_next   = seed_reg;
                        idx_next   = 2'd0;
                        state_next = S_MIX_ADD;
                    end
                    else if (byte_count != '0)
                    begin
                        rem_next   = (byte_count > MAX_BYTES) ? MAX_BYTES : byte_count;
                        state_next = S_GEN_MUL5;
                    end
                end
            end
            S_MIX_ADD:
            begin
                acc_next   = acc_sum;
                z_next     = acc_sum ^ (acc_sum >> 30);
                mph_next   = 2'd0;
                state_next = S_MUL_A;
            end
            S_MUL_A, S_MUL_B:
            begin
                if (mph_reg == 2'd0)
                begin
                    prod_next = mul_p;
                end
                else
                begin
                    prod_next[WORD_W-1:HALF_W] = prod_reg[WORD_W-1:HALF_W] +
                                                 mul_p[HALF_W-1:0];
                end
                if (mph_reg == 2'd2)
                begin
                    mph_next   = 2'd0;
                    state_next = (state_reg == S_MUL_A) ? S_XOR27 : S_XOR31;
                end
                else
                begin
                    mph_next = mph_reg + 2'd1;
                end
            end
            S_XOR27:
            begin
                z_next     = prod_reg ^ (prod_reg >> 27);
                state_next = S_MUL_B;
            end
            S_XOR31:
            begin
                lane_next[idx_reg] = prod_reg ^ (prod_reg >> 31);
                idx_next           = idx_reg + 2'd1;
                state_next         = (idx_reg == 2'd3) ? S_ZCHK : S_MIX_ADD;
            end
            S_ZCHK:
            begin
                if ((lane_reg[0] | lane_reg[1] | lane_reg[2] | lane_reg[3]) == '0)
                begin
                    lane_next[0] = WORD_W'(1);
                end
                state_next = S_IDLE;
            end
            S_GEN_MUL5:
            begin
                z_next     = lane_reg[1] + (lane_reg[1] << 2);
                state_next = S_GEN_MUL9;
            end
            S_GEN_MUL9:
            begin
                word_next    = rot7 + (rot7 << 3);
                lane_next[2] = s2x ^ (lane_reg[1] << 17);
                lane_next[3] = {s3x[18:0], s3x[63:19]};
                lane_next[1] = lane_reg[1] ^ s2x;
                lane_next[0] = lane_reg[0] ^ s3x;
                if (rem_reg > COUNT_W'(8))
                begin
                    vb_next   = VB_W'(8);
                    last_next = 1'b0;
                    rem_next  = rem_reg - COUNT_W'(8);
                end
                else
                begin
                    vb_next   = rem_reg[VB_W-1:0];
                    last_next = 1'b1;
                    rem_next  = '0;
                end
                state_next = S_GEN_OUT;
            end
            S_GEN_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_word_next  = word_reg;
                    out_vb_next    = vb_reg;
                    out_last_next  = last_reg;
                    state_next     = last_reg ? S_IDLE : S_GEN_MUL5;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_MIX_ADD;
            acc_reg       <= '0;
            idx_reg       <= 2'd0;
            mph_reg       <= 2'd0;
            seed_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            idx_reg       <= idx_next;
            mph_reg       <= mph_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                seed_reg <= seed;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        z_reg        <= z_next;
        prod_reg     <= prod_next;
        lane_reg     <= lane_next;
        rem_reg      <= rem_next;
        word_reg     <= word_next;
        vb_reg       <= vb_next;
        last_reg     <= last_next;
        out_word_reg <= out_word_next;
        out_vb_reg   <= out_vb_next;
        out_last_reg <= out_last_next;
    end

endmodule

/* hw/rtl/sxbg_checker.sv */
// Port-level assertions for the seeded xoshiro256** byte generator.
// Depends on sxbg_pkg; bound to seeded_xoshiro_byte_generator below.
module sxbg_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_stall,
    input logic                         action,
    input logic [sxbg_pkg::COUNT_W-1:0] byte_count,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [sxbg_pkg::WORD_W-1:0]  random_word,
    input logic [sxbg_pkg::VB_W-1:0]    valid_bytes,
    input logic                         last_word
);
    import sxbg_pkg::*;

    // a held output beat keeps its word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(random_word))
        else $error("output beat changed while stalled");

    // any accepted reseed or non-empty generate keeps the input busy
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (action == ACT_RESEED || byte_count != '0) |=> in_stall)
        else $error("input not stalled after accepting work");

    a_vb_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> valid_bytes != '0 && valid_bytes <= VB_W'(8))
        else $error("valid_bytes out of range");

    // only the final word of a request may be partial
    a_partial_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_word |-> valid_bytes == VB_W'(8))
        else $error("partial word not marked last");

endmodule

bind seeded_xoshiro_byte_generator sxbg_checker u_sxbg_checker (.*);

/* sim/seeded_xoshiro_byte_generator_tb.sv */
// Self-checking testbench for seeded_xoshiro_byte_generator: predicts splitmix64 reseeds and
// xoshiro256** words, drives requests and seed writes with random gaps and output stalls.
// Depends on sxbg_pkg and the seeded_xoshiro_byte_generator RTL.
`timescale 1ns / 1ps

module seeded_xoshiro_byte_generator_tb;

    import sxbg_pkg::*;

    localparam int MAX_WORDS   = 64;
    localparam int MAX_BYTES   = MAX_WORDS * 8;
    localparam int IDLE_PAUSE  = 60;
    localparam int STUCK_LIMIT = 3000;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [VB_W-1:0]   nbytes;
        logic              last;
    } rand_beat_t;

    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                cfg_valid  = 1'b0;
    logic                cfg_ready;
    logic [WORD_W-1:0]   seed       = '0;
    logic                in_valid   = 1'b0;
    logic                in_stall;
    logic                action     = ACT_GENERATE;
    logic [COUNT_W-1:0]  byte_count = '0;
    logic                out_valid;
    logic                out_stall  = 1'b0;
    logic [WORD_W-1:0]   random_word;
    logic [VB_W-1:0]     valid_bytes;
    logic                last_word;

    logic [WORD_W-1:0]   lanes [4];
    logic [WORD_W-1:0]   seed_shadow;
    rand_beat_t          beat_q [$];
    rand_beat_t          want_beat;

    bit                  gaps_on      = 1'b1;
    int                  errors       = 0;
    int                  words_seen   = 0;
    int                  n_requests   = 0;
    int                  n_reseeds    = 0;
    int                  n_seed_wr    = 0;
    int                  stall_left   = 0;
    int                  stuck_cycles = 0;

    seeded_xoshiro_byte_generator #(
        .MAX_WORDS(MAX_WORDS)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .seed(seed),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .action(action),
        .byte_count(byte_count),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .random_word(random_word),
        .valid_bytes(valid_bytes),
        .last_word(last_word)
    );

    always #10 clk = ~clk;

    // ---------------------------------------------------------------- predictor

    function automatic logic [WORD_W-1:0] rot_left(input logic [WORD_W-1:0] v, input int k);
        return (v << k) | (v >> (WORD_W - k));
    endfunction

    function automatic void expand_lanes();
        logic [WORD_W-1:0] acc;
        logic [WORD_W-1:0] z;
        acc = seed_shadow;
        for (int i = 0; i < 4; i++)
        begin
            acc = acc + GOLDEN_GAMMA;
            z = acc;
            z = (z ^ (z >> 30)) * MIX_MUL_A;
            z = (z ^ (z >> 27)) * MIX_MUL_B;
            lanes[i] = z ^ (z >> 31);
        end
        // all-zero lanes would lock the generator
        if ((lanes[0] | lanes[1] | lanes[2] | lanes[3]) == '0)
        begin
            lanes[0] = 64'd1;
        end
    endfunction

    function automatic logic [WORD_W-1:0] step_lanes();
        logic [WORD_W-1:0] prod;
        logic [WORD_W-1:0] rot;
        logic [WORD_W-1:0] out_w;
        logic [WORD_W-1:0] sh;
        prod  = lanes[1] * 64'd5;
        rot   = rot_left(prod, 7);
        out_w = rot * 64'd9;
        sh    = lanes[1] << 17;
        lanes[2] = lanes[2] ^ lanes[0];
        lanes[3] = lanes[3] ^ lanes[1];
        lanes[1] = lanes[1] ^ lanes[2];
        lanes[0] = lanes[0] ^ lanes[3];
        lanes[2] = lanes[2] ^ sh;
        lanes[3] = rot_left(lanes[3], 45);
        return out_w;
    endfunction

    function automatic void predict_request(input logic act, input logic [COUNT_W-1:0] cnt);
        int left;
        int chunk;
        rand_beat_t b;
        n_requests++;
        if (act == ACT_RESEED)
        begin
            expand_lanes();
            n_reseeds++;
            return;
        end
        left = (cnt > MAX_BYTES) ? MAX_BYTES : int'(cnt);
        while (left > 0)
        begin
            chunk    = (left < 8) ? left : 8;
            b.word   = step_lanes();
            b.nbytes = chunk[VB_W-1:0];
            left     = left - chunk;
            b.last   = (left == 0);
            beat_q.push_back(b);
        end
    endfunction

    // ---------------------------------------------------------------- helpers

    function automatic int pick_gap();
        int r;
        if (!gaps_on)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    task automatic report_error(input string what, input logic [WORD_W-1:0] got,
                                input logic [WORD_W-1:0] want);
        $display("%0t ERROR %s: got %h, want %h", $time, what, got, want);
        errors++;
    endtask

    task automatic send_req(input logic act, input logic [COUNT_W-1:0] cnt);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        action     <= act;
        byte_count <= cnt;
        do @(posedge clk); while (in_stall);
        predict_request(act, cnt);
    endtask

    // lower valid, let every expected word arrive, then let a reseed finish
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (beat_q.size() != 0) @(posedge clk);
        repeat (IDLE_PAUSE) @(posedge clk);
    endtask

    task automatic write_seed(input logic [WORD_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        seed      <= value;
        do @(posedge clk); while (!cfg_ready);
        seed_shadow = value;
        n_seed_wr++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // ---------------------------------------------------------------- output side

    always @(negedge clk)
    begin
        if (!rst_n || !gaps_on)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            out_stall <= 1'b1;
            stall_left = pick_gap();
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            words_seen++;
            if (beat_q.size() == 0)
            begin
                report_error("word with no request pending", random_word, '0);
            end
            else
            begin
                want_beat = beat_q.pop_front();
                if (random_word !== want_beat.word)
                    report_error("random_word", random_word, want_beat.word);
                if (valid_bytes !== want_beat.nbytes)
                    report_error("valid_bytes", 64'(valid_bytes), 64'(want_beat.nbytes));
                if (last_word !== want_beat.last)
                    report_error("last_word", 64'(last_word), 64'(want_beat.last));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        begin
            stuck_cycles = 0;
        end
        else
        begin
            stuck_cycles++;
        end
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("%0t timeout: no beat for %0d cycles", $time, STUCK_LIMIT);
            $display("** seeded_xoshiro_byte_generator: FAILED **");
            $finish;
        end
    end

    // ---------------------------------------------------------------- tests

    // lanes straight from the post-reset expansion of seed 0
    task automatic test_reset_stream();
        send_req(ACT_GENERATE, 10'd1);
        send_req(ACT_GENERATE, 10'd8);
        send_req(ACT_GENERATE, 10'd9);
        send_req(ACT_GENERATE, 10'd16);
        wait_idle();
    endtask

    // zero count, partial words, saturation above 512, reseed ignoring its count
    task automatic test_count_edges();
        send_req(ACT_GENERATE, 10'd0);
        send_req(ACT_GENERATE, 10'd7);
        send_req(ACT_GENERATE, 10'd511);
        send_req(ACT_GENERATE, 10'd512);
        send_req(ACT_GENERATE, 10'd513);
        send_req(ACT_GENERATE, 10'd1023);
        send_req(ACT_RESEED, 10'd1023);
        wait_idle();
    endtask

    // a repeated reseed from the same seed must replay the same words
    task automatic test_seed_extremes();
        logic [WORD_W-1:0] seeds [3];
        seeds[0] = '0;
        seeds[1] = '1;
        seeds[2] = 64'h8000_0000_0000_0001;
        foreach (seeds[i])
        begin
            write_seed(seeds[i]);
            send_req(ACT_RESEED, 10'd0);
            send_req(ACT_GENERATE, 10'd17);
            send_req(ACT_RESEED, 10'd0);
            send_req(ACT_GENERATE, 10'd17);
            wait_idle();
        end
    endtask

    task automatic test_random_traffic();
        int r;
        int pick;
        logic [WORD_W-1:0] s;
        for (int phase = 0; phase < 5; phase++)
        begin
            gaps_on = (phase != 2);
            pick = $urandom_range(0, 9);
            if (pick == 0)
                s = '0;
            else if (pick == 1)
                s = '1;
            else
                s = {$urandom, $urandom};
            write_seed(s);
            send_req(ACT_RESEED, COUNT_W'($urandom));
            for (int n = 0; n < 17; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                    send_req(ACT_GENERATE, COUNT_W'($urandom_range(1, 64)));
                else if (r < 80)
                    send_req(ACT_GENERATE, COUNT_W'($urandom_range(65, MAX_BYTES)));
                else if (r < 85)
                    send_req(ACT_GENERATE, COUNT_W'($urandom_range(MAX_BYTES + 1, 1023)));
                else if (r < 89)
                    send_req(ACT_GENERATE, 10'd0);
                else
                    send_req(ACT_RESEED, COUNT_W'($urandom));
                // sender holds off until the generator has drained
                if (n == 10)
                begin
                    @(negedge clk);
                    in_valid <= 1'b0;
                    while (beat_q.size() != 0) @(posedge clk);
                end
            end
            wait_idle();
        end
        gaps_on = 1'b1;
    endtask

    initial
    begin
        seed_shadow = '0;
        expand_lanes();
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        wait_idle();

        test_reset_stream();
        test_count_edges();
        test_seed_extremes();
        test_random_traffic();

        wait_idle();
        $display("covered %0d requests (%0d reseeds), %0d seed writes incl. all-zero/all-one",
                 n_requests, n_reseeds, n_seed_wr);
        $display("checked %0d words with count saturation, partial words and random stalls",
                 words_seen);
        if (errors == 0)
        begin
            $display("** seeded_xoshiro_byte_generator: PASSED **");
        end
        else
        begin
            $display("%0d mismatches", errors);
            $display("** seeded_xoshiro_byte_generator: FAILED **");
        end
        $finish;
    end

endmodule
